/* sv/spi_pkg.sv */
package spi_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ANGLE,
    ST_PULSE,
    ST_OUT
  } state_t;

  localparam int ANGLE_W   = 8;
  localparam int STEP_W    = 7;
  localparam int PULSE_W   = 12;
  // Magnitude of (target - prev) * k fits in 8 x 7 bits.
  localparam int DIV_W     = ANGLE_W + STEP_W;
  localparam int DIV_CNT_W = 4;
  localparam int REM_W     = STEP_W;

  localparam logic [STEP_W-1:0]  MAX_STEPS      = 7'd64;
  localparam logic [ANGLE_W-1:0] POSE_RESET     = 8'd90;
  localparam logic [ANGLE_W-1:0] FULL_SCALE_DEG = 8'd180;
  localparam logic [PULSE_W-1:0] PULSE_MIN      = 12'd499;
  localparam logic [PULSE_W-1:0] PULSE_MAX      = 12'd2499;

  // angle * 2000 / 180 = angle * 100 / 9, taken as (angle * 100 * 7282) >> 16.
  // Exact for every angle up to full scale.
  localparam int                 RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_X100  = 20'd728200;
  localparam int                 RECIP_SHIFT = 16;
  localparam int                 SCALED_W    = ANGLE_W + RECIP_W;

endpackage

/* sv/servo_pose_interpolator.sv */
// Servo pose interpolator. One input transaction on the s_ group carries a
// target pose (one absolute angle in degrees per channel) and a step count N;
// zero is taken as one step and anything above 64 as 64. The block answers
// with N output transactions on the m_ group. Output k (1..N) holds, for
// every channel, the compare value of prev + trunc((target - prev) * k / N),
// converted as floor(angle * 2000 / 180) + 499 and clamped to 499..2499.
// The last output of a move carries m_tlast, and the stored pose then becomes
// the target. After reset every channel rests at 90 degrees. All arithmetic
// runs through one shared sequencer: per channel it forms the product
// |target - prev| * k, a restoring divider divides it by N, the sign is
// applied and the angle is scaled to a pulse. Once every channel is done,
// the output is offered and held until the sink takes it. The block accepts
// no new pose until the last output of a move has been taken.
module servo_pose_interpolator #(
  parameter int CHANNELS = 6
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // target_angle_0 .. target_angle_{CHANNELS-1} (8 bits each), step_count (7 bits)
  input  logic [((CHANNELS*8+7+7)/8)*8-1:0]            s_tdata,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // pulse_0 .. pulse_{CHANNELS-1} (12 bits each), zero padded to whole bytes
  output logic [((CHANNELS*12+7)/8)*8-1:0]             m_tdata,
  // last_step
  output logic                                         m_tlast
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  spi_pkg::state_t state, state_next;

  logic [spi_pkg::ANGLE_W-1:0]   target   [CHANNELS];
  logic [spi_pkg::ANGLE_W-1:0]   pose     [CHANNELS];
  logic [spi_pkg::PULSE_W-1:0]   pulse    [CHANNELS];
  logic [spi_pkg::STEP_W-1:0]    steps;
  logic [spi_pkg::STEP_W-1:0]    k;
  logic [CH_W-1:0]               ch;
  logic                          neg;
  logic [spi_pkg::DIV_W-1:0]     dividend;
  logic [spi_pkg::REM_W-1:0]     rem;
  logic [spi_pkg::DIV_CNT_W-1:0] cnt;
  logic [spi_pkg::ANGLE_W-1:0]   angle;

  logic                          in_fire;
  logic                          out_fire;
  logic                          last_ch;
  logic                          div_done;
  logic                          move_done;

  logic [spi_pkg::STEP_W-1:0]    step_in;
  logic [spi_pkg::STEP_W-1:0]    step_sat;
  logic [spi_pkg::ANGLE_W-1:0]   cur_target;
  logic [spi_pkg::ANGLE_W-1:0]   cur_pose;
  logic [spi_pkg::ANGLE_W-1:0]   abs_diff;
  logic [spi_pkg::DIV_W-1:0]     product;
  logic [spi_pkg::REM_W:0]       trial;
  logic                          trial_ge;
  logic [spi_pkg::REM_W-1:0]     rem_next;
  logic [spi_pkg::ANGLE_W-1:0]   quot;
  logic [spi_pkg::SCALED_W-1:0]  scaled;
  logic [spi_pkg::PULSE_W-1:0]   pulse_val;

  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign last_ch   = (ch == CH_W'(CHANNELS - 1));
  assign div_done  = (cnt == spi_pkg::DIV_CNT_W'(spi_pkg::DIV_W - 1));
  assign move_done = (k == steps);

  // Step count saturates to 1..64.
  assign step_in  = s_tdata[CHANNELS*spi_pkg::ANGLE_W +: spi_pkg::STEP_W];
  always_comb begin
    if (step_in == '0) begin
      step_sat = spi_pkg::STEP_W'(1);
    end else if (step_in > spi_pkg::MAX_STEPS) begin
      step_sat = spi_pkg::MAX_STEPS;
    end else begin
      step_sat = step_in;
    end
  end

  // Shared arithmetic for the channel under work.
  assign cur_target = target[ch];
  assign cur_pose   = pose[ch];
  assign abs_diff   = (cur_target >= cur_pose) ? (cur_target - cur_pose)
                                                : (cur_pose - cur_target);
  assign product    = spi_pkg::DIV_W'(abs_diff) * spi_pkg::DIV_W'(k);

  // One restoring divide step per cycle; quotient bits shift into dividend.
  assign trial    = {rem, dividend[spi_pkg::DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, steps});
  assign rem_next = trial_ge ? spi_pkg::REM_W'(trial - {1'b0, steps})
                             : trial[spi_pkg::REM_W-1:0];
  assign quot     = dividend[spi_pkg::ANGLE_W-1:0];

  // The quotient never exceeds |target - prev|, so the angle stays in range.
  assign scaled = spi_pkg::SCALED_W'(angle) * spi_pkg::SCALED_W'(spi_pkg::RECIP_X100);
  always_comb begin
    if (angle > spi_pkg::FULL_SCALE_DEG) begin
      pulse_val = spi_pkg::PULSE_MAX;
    end else begin
      pulse_val = scaled[spi_pkg::RECIP_SHIFT +: spi_pkg::PULSE_W] + spi_pkg::PULSE_MIN;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      spi_pkg::ST_IDLE:  if (in_fire) state_next = spi_pkg::ST_MUL;
      spi_pkg::ST_MUL:   state_next = spi_pkg::ST_DIV;
      spi_pkg::ST_DIV:   if (div_done) state_next = spi_pkg::ST_ANGLE;
      spi_pkg::ST_ANGLE: state_next = spi_pkg::ST_PULSE;
      spi_pkg::ST_PULSE: state_next = last_ch ? spi_pkg::ST_OUT : spi_pkg::ST_MUL;
      spi_pkg::ST_OUT: begin
        if (out_fire) begin
          state_next = move_done ? spi_pkg::ST_IDLE : spi_pkg::ST_MUL;
        end
      end
      default:           state_next = spi_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      spi_pkg::ST_IDLE: s_tready = 1'b1;
      spi_pkg::ST_OUT:  m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stored pose: reset to the rest position, replaced by the target when the
  // last output of a move is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pose[c] <= spi_pkg::POSE_RESET;
      end
    end else if (state == spi_pkg::ST_OUT && out_fire && move_done) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pose[c] <= target[c];
      end
    end
  end

  // Sequencer counters and the stored step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      steps <= spi_pkg::STEP_W'(1);
      ch    <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        spi_pkg::ST_IDLE: begin
          if (in_fire) begin
            steps <= step_sat;
            k     <= spi_pkg::STEP_W'(1);
            ch    <= '0;
          end
        end
        spi_pkg::ST_MUL: begin
          cnt <= '0;
        end
        spi_pkg::ST_DIV: begin
          cnt <= cnt + 1'b1;
        end
        spi_pkg::ST_PULSE: begin
          if (!last_ch) begin
            ch <= ch + 1'b1;
          end
        end
        spi_pkg::ST_OUT: begin
          if (out_fire && !move_done) begin
            k  <= k + 1'b1;
            ch <= '0;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      spi_pkg::ST_IDLE: begin
        if (in_fire) begin
          for (int c = 0; c < CHANNELS; c++) begin
            target[c] <= s_tdata[c*spi_pkg::ANGLE_W +: spi_pkg::ANGLE_W];
          end
        end
      end
      spi_pkg::ST_MUL: begin
        neg      <= (cur_target < cur_pose);
        dividend <= product;
        rem      <= '0;
      end
      spi_pkg::ST_DIV: begin
        rem      <= rem_next;
        dividend <= {dividend[spi_pkg::DIV_W-2:0], trial_ge};
      end
      spi_pkg::ST_ANGLE: begin
        angle <= neg ? (cur_pose - quot) : (cur_pose + quot);
      end
      spi_pkg::ST_PULSE: begin
        pulse[ch] <= pulse_val;
      end
      default: begin
        angle <= angle;
      end
    endcase
  end

  always_comb begin
    m_tdata = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      m_tdata[c*spi_pkg::PULSE_W +: spi_pkg::PULSE_W] = pulse[c];
    end
  end

  assign m_tlast = move_done;

endmodule

/* sv/spi_checker.sv */
module spi_checker #(
  parameter int CHANNELS = 6
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((CHANNELS*12+7)/8)*8-1:0]  m_tdata,
  input logic                              m_tlast
);

  logic pulse_bad;

  always_comb begin
    pulse_bad = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (m_tdata[c*spi_pkg::PULSE_W +: spi_pkg::PULSE_W] < spi_pkg::PULSE_MIN ||
          m_tdata[c*spi_pkg::PULSE_W +: spi_pkg::PULSE_W] > spi_pkg::PULSE_MAX) begin
        pulse_bad = 1'b1;
      end
    end
  end

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // One move at a time: never taking a pose while a result is offered.
  a_one_move: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // Every offered pulse lies in the servo range.
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !pulse_bad)
    else $error("pulse out of range");

  // A pose taken starts a move; the input closes at once.
  a_in_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still ready after a pose was taken");

  // A move only ends with a result marked last.
  a_move_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("move ended without a last result");

endmodule

bind servo_pose_interpolator spi_checker #(.CHANNELS(CHANNELS)) u_spi_checker (.*);

/* sim/tb_servo_pose_interpolator.sv */
module tb_servo_pose_interpolator;

  localparam int NCH          = 6;
  localparam int SW           = ((NCH*8+7+7)/8)*8;
  localparam int MW           = ((NCH*12+7)/8)*8;
  localparam int PULSE_SPAN   = 2000;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int DRAIN_CYCLES = 250;
  localparam int QUIET_TAIL   = 16;
  localparam int REPORT_CAP   = 100;

  typedef struct packed {
    logic [6:0]              steps;
    logic [NCH-1:0][7:0]     target;
  } pose_cmd_t;

  typedef struct packed {
    logic                    last;
    logic [NCH-1:0][11:0]    pulse;
  } servo_frame_t;

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic [SW-1:0] s_tdata  = '0;
  logic          m_tready = 1'b0;
  logic          s_tready;
  logic          m_tvalid;
  logic [MW-1:0] m_tdata;
  logic          m_tlast;

  pose_cmd_t    move_q[$];
  servo_frame_t frame_expect_q[$];
  logic [7:0]   pose_now[NCH];
  pose_cmd_t    move_on_bus;
  logic         src_next_valid;
  logic         snk_next_ready;
  int           src_idle;
  int           snk_idle;
  int           moves_total;
  int           moves_taken;
  int           frames_seen;
  int           error_count;
  int           cycle_count;

  servo_pose_interpolator #(.CHANNELS(NCH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [11:0] deg_to_pulse(input int deg);
    int p;
    p = deg * PULSE_SPAN / int'(spi_pkg::FULL_SCALE_DEG) + int'(spi_pkg::PULSE_MIN);
    if (p > int'(spi_pkg::PULSE_MAX)) p = int'(spi_pkg::PULSE_MAX);
    return p[11:0];
  endfunction

  // Expands one accepted move into its interpolated frames and advances the pose.
  task automatic plan_move(input pose_cmd_t cmd);
    int n;
    int diff;
    int ang;
    servo_frame_t f;
    n = int'(cmd.steps);
    if (n == 0) n = 1;
    if (n > int'(spi_pkg::MAX_STEPS)) n = int'(spi_pkg::MAX_STEPS);
    for (int k = 1; k <= n; k++) begin
      for (int c = 0; c < NCH; c++) begin
        diff = int'(cmd.target[c]) - int'(pose_now[c]);
        ang  = int'(pose_now[c]) + (diff * k) / n;
        f.pulse[c] = deg_to_pulse(ang);
      end
      f.last = (k == n);
      frame_expect_q.push_back(f);
    end
    for (int c = 0; c < NCH; c++) pose_now[c] = cmd.target[c];
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= REPORT_CAP)
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    else if (error_count == REPORT_CAP + 1)
      $display("%0t: further mismatches are counted but not shown", $time);
  endtask

  task automatic check_frame();
    servo_frame_t want;
    if (frame_expect_q.size() == 0) begin
      note_mismatch("unexpected frame, pending count", 0, 1);
    end else begin
      want = frame_expect_q.pop_front();
      for (int c = 0; c < NCH; c++)
        if (m_tdata[12*c +: 12] !== want.pulse[c])
          note_mismatch($sformatf("frame %0d pulse_%0d", frames_seen, c),
                        int'(want.pulse[c]), int'(m_tdata[12*c +: 12]));
      if (m_tlast !== want.last)
        note_mismatch($sformatf("frame %0d last_step", frames_seen),
                      int'(want.last), int'(m_tlast));
    end
    frames_seen++;
  endtask

  task automatic add_move(input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
                          input logic [7:0] a3, input logic [7:0] a4, input logic [7:0] a5,
                          input logic [6:0] n);
    pose_cmd_t cmd;
    cmd.target = {a5, a4, a3, a2, a1, a0};
    cmd.steps  = n;
    move_q.push_back(cmd);
  endtask

  function automatic logic [7:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1:       return 8'($urandom_range(181, 255));
      2:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 180));
    endcase
  endfunction

  function automatic logic [6:0] pick_steps();
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return 7'($urandom_range(9, 127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  // Source side: offers queued moves, records each one when it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_idle = 0;
    end else begin
      src_next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        plan_move(move_on_bus);
        moves_taken++;
        src_next_valid = 1'b0;
      end
      if (!src_next_valid) begin
        if (src_idle > 0) begin
          src_idle--;
        end else if (move_q.size() > 0) begin
          if (move_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            src_idle = $urandom_range(0, 3);
          end else begin
            move_on_bus = move_q.pop_front();
            s_tdata <= SW'({1'b0, move_on_bus.steps, move_on_bus.target});
            src_next_valid = 1'b1;
          end
        end
      end
      s_tvalid <= src_next_valid;
    end
  end

  // Sink side: checks each accepted frame and stalls in short bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_idle = 0;
    end else begin
      if (m_tvalid && m_tready) check_frame();
      if (snk_idle > 0) begin
        snk_idle--;
        snk_next_ready = 1'b0;
      end else if (move_q.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        snk_idle = $urandom_range(0, 3);
        snk_next_ready = 1'b0;
      end else begin
        snk_next_ready = 1'b1;
      end
      m_tready <= snk_next_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d frames still awaited",
               $time, cycle_count, frame_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NCH; c++) pose_now[c] = spi_pkg::POSE_RESET;

    // Directed moves: range ends, saturation of the pulse above full scale,
    // zero and oversized step counts, both signs of the truncated quotient.
    add_move(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   7'd1);
    add_move(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 7'd1);
    add_move(8'd180, 8'd180, 8'd180, 8'd180, 8'd180, 8'd180, 7'd0);
    add_move(8'd0,   8'd255, 8'd180, 8'd1,   8'd179, 8'd90,  7'd64);
    add_move(8'd255, 8'd0,   8'd1,   8'd180, 8'd90,  8'd179, 7'd127);
    add_move(8'd7,   8'd200, 8'd13,  8'd250, 8'd91,  8'd89,  7'd3);
    add_move(8'd7,   8'd200, 8'd13,  8'd250, 8'd91,  8'd89,  7'd5);
    add_move(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  7'd100);
    add_move(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  7'd65);
    add_move(8'd181, 8'd182, 8'd0,   8'd1,   8'd2,   8'd179, 7'd2);
    add_move(8'd90,  8'd90,  8'd90,  8'd90,  8'd90,  8'd90,  7'd63);
    add_move(8'd10,  8'd170, 8'd45,  8'd135, 8'd0,   8'd180, 7'd7);
    add_move(8'd11,  8'd169, 8'd46,  8'd134, 8'd1,   8'd179, 7'd6);
    add_move(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   7'd0);
    add_move(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 7'd9);
    add_move(8'd128, 8'd64,  8'd32,  8'd16,  8'd8,   8'd4,   7'd4);

    for (int i = 0; i < 134; i++)
      add_move(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
               pick_angle(), pick_angle(), pick_steps());
    moves_total = move_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (moves_taken < moves_total) @(posedge clk);
    while (frame_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pose moves and %0d interpolated frames in %0d cycles,",
             moves_taken, frames_seen, cycle_count);
    $display("with %0d mismatches and %0d frames left unanswered.",
             error_count, frame_expect_q.size());
    if (error_count == 0 && frame_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/spi_pkg.sv
sv/servo_pose_interpolator.sv
sv/spi_checker.sv
sim/tb_servo_pose_interpolator.sv
